// ===== rtl/wla_pkg.sv =====
package wla_pkg;

  localparam int unsigned WINDOW_LEN_DEF  = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  // input command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEAK_UPD,
    S_LEAK_OUT,
    S_AVG_START,
    S_AVG_RUN,
    S_OUT_WAIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic warm_add;
    logic latch_sample;
    logic leak_update;
    logic div_start;
    logic out_load;
    logic out_window;
  } dp_cmd_t;

  typedef struct packed {
    logic warm;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/warmup_leaky_average_filter_core.sv =====
// Warm-up leaky average filter.
// Input channel: in_valid / in_stall with command and sample. command = 0 folds
// the sample into the running sum and yields one average; command = 1 clears
// the sum and warm-up count and yields nothing.
// Output channel: out_valid / out_stall with average, held in a register.
// A transfer happens on a clock edge with valid high and stall low.
// One item at a time: in_stall is high from the transfer until the result is
// loaded into the output register. During warm-up the average is sum over count
// from a restoring divider retiring two quotient bits per cycle: the transfer
// adds the sample, S_AVG_START starts the divider, and S_AVG_RUN loads the
// quotient into the output register when the divider is done. After warm-up
// the division by WINDOW_LEN is a reciprocal multiply: the transfer latches the
// sample, S_LEAK_UPD updates the sum and S_LEAK_OUT loads the average.
// A clear leaves the core idle and ready for the next item.
// While the receiver stalls, a finished average waits until the output register
// is free or being emptied, and in_stall stays high meanwhile.
// Synchronous reset clears the sum, warm-up count and out_valid.
module warmup_leaky_average_filter_core #(
  parameter int unsigned WINDOW_LEN  = wla_pkg::WINDOW_LEN_DEF,
  parameter int unsigned SAMPLE_BITS = wla_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   command,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] average
);

  wla_pkg::dp_cmd_t    cmd;
  wla_pkg::dp_status_t status;

  wla_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command (command),
    .status  (status),
    .cmd     (cmd)
  );

  wla_datapath #(
    .WINDOW_LEN (WINDOW_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .sample   (sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .average  (average)
  );

endmodule

// ===== rtl/wla_div.sv =====
module wla_div #(
  parameter int unsigned DIVIDEND_W = 16,
  parameter int unsigned DIVISOR_W  = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  // restoring division, two quotient bits per cycle
  localparam int unsigned DE    = DIVIDEND_W + (DIVIDEND_W % 2);
  localparam int unsigned STEPS = DE / 2;
  localparam int unsigned SCW   = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic                 busy;
  logic [SCW-1:0]       cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [DE-1:0]        quo;
  logic [DIVISOR_W-1:0] rem_next;
  logic [DE-1:0]        quo_next;

  always_comb begin
    logic [DIVISOR_W:0] ext;
    logic [DIVISOR_W-1:0] r;
    logic [DE-1:0] q;
    r = rem;
    q = quo;
    for (int k = 0; k < 2; k++) begin
      ext = {r, q[DE-1]};
      q   = {q[DE-2:0], 1'b0};
      if (ext >= {1'b0, dsr}) begin
        ext  = ext - {1'b0, dsr};
        q[0] = 1'b1;
      end
      r = ext[DIVISOR_W-1:0];
    end
    rem_next = r;
    quo_next = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= DE'(dividend);
        dsr  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt + 1'b1;
        if (cnt == SCW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo[DIVIDEND_W-1:0];

endmodule

// ===== rtl/wla_datapath.sv =====
module wla_datapath #(
  parameter int unsigned WINDOW_LEN  = wla_pkg::WINDOW_LEN_DEF,
  parameter int unsigned SAMPLE_BITS = wla_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  wla_pkg::dp_cmd_t       cmd,
  output wla_pkg::dp_status_t    status,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] average
);

  localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int unsigned CNT_W = $clog2(WINDOW_LEN + 1);

  // sum / WINDOW_LEN as a multiply by the rounded-up reciprocal; exact for any SUM_W-bit sum
  localparam int unsigned     SHIFT      = SUM_W + $clog2(WINDOW_LEN);
  localparam int unsigned     PROD_W     = 2 * SUM_W + 1;
  localparam longint unsigned RECIP_WIDE =
    ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [SUM_W:0]  RECIP      = (SUM_W + 1)'(RECIP_WIDE);

  logic [SUM_W-1:0]       running_sum;
  logic [SUM_W-1:0]       running_sum_next;
  logic [CNT_W-1:0]       warmup_count;
  logic [SAMPLE_BITS-1:0] smp;
  logic                   div_done;
  logic [SUM_W-1:0]       quotient;
  logic [PROD_W-1:0]      win_prod;
  logic [SUM_W-1:0]       win_quot;

  // divides the sum by the warm-up count during warm-up
  wla_div #(
    .DIVIDEND_W(SUM_W),
    .DIVISOR_W (CNT_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(running_sum),
    .divisor (warmup_count),
    .done    (div_done),
    .quotient(quotient)
  );

  assign win_prod = PROD_W'(running_sum) * PROD_W'(RECIP);
  assign win_quot = win_prod[SHIFT +: SUM_W];

  always_comb begin
    running_sum_next = running_sum;
    if (cmd.clear) begin
      running_sum_next = '0;
    end else if (cmd.warm_add) begin
      running_sum_next = running_sum + SUM_W'(sample);
    end else if (cmd.leak_update) begin
      running_sum_next = running_sum - win_quot + SUM_W'(smp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      warmup_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      running_sum <= running_sum_next;
      if (cmd.clear) begin
        warmup_count <= '0;
      end else if (cmd.warm_add) begin
        warmup_count <= warmup_count + 1'b1;
      end
      if (cmd.latch_sample) begin
        smp <= sample;
      end
      if (cmd.out_load) begin
        average   <= cmd.out_window ? win_quot[SAMPLE_BITS-1:0] : quotient[SAMPLE_BITS-1:0];
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.warm     = warmup_count < CNT_W'(WINDOW_LEN);
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || !out_stall;

endmodule

// ===== rtl/wla_ctrl.sv =====
module wla_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                command,
  input  wla_pkg::dp_status_t status,
  output wla_pkg::dp_cmd_t    cmd
);

  wla_pkg::state_t state;
  wla_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wla_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wla_pkg::S_IDLE: begin
        if (in_valid && command != wla_pkg::CMD_CLEAR) begin
          state_next = status.warm ? wla_pkg::S_AVG_START : wla_pkg::S_LEAK_UPD;
        end
      end
      wla_pkg::S_LEAK_UPD: state_next = wla_pkg::S_LEAK_OUT;
      wla_pkg::S_LEAK_OUT: begin
        if (status.out_free) state_next = wla_pkg::S_IDLE;
      end
      wla_pkg::S_AVG_START: state_next = wla_pkg::S_AVG_RUN;
      wla_pkg::S_AVG_RUN: begin
        if (status.div_done) begin
          state_next = status.out_free ? wla_pkg::S_IDLE : wla_pkg::S_OUT_WAIT;
        end
      end
      wla_pkg::S_OUT_WAIT: begin
        if (status.out_free) state_next = wla_pkg::S_IDLE;
      end
      default: state_next = wla_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      wla_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (command == wla_pkg::CMD_CLEAR) begin
            cmd.clear = 1'b1;
          end else if (status.warm) begin
            cmd.warm_add = 1'b1;
          end else begin
            cmd.latch_sample = 1'b1;
          end
        end
      end
      wla_pkg::S_LEAK_UPD: cmd.leak_update = 1'b1;
      wla_pkg::S_LEAK_OUT: begin
        cmd.out_window = 1'b1;
        cmd.out_load   = status.out_free;
      end
      wla_pkg::S_AVG_START:  cmd.div_start = 1'b1;
      wla_pkg::S_AVG_RUN:    cmd.out_load = status.div_done && status.out_free;
      wla_pkg::S_OUT_WAIT:   cmd.out_load = status.out_free;
      default:               cmd = '0;
    endcase
  end

endmodule

// ===== bench/wla_avg_checker.sv =====
`timescale 1ns / 1ps

module wla_avg_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        command,
  input  logic [11:0] sample,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [11:0] average,
  output int          errors,
  output int          pending
);

  localparam int unsigned WIN = wla_pkg::WINDOW_LEN_DEF;

  logic [15:0] leak_sum;
  logic [4:0]  warm_cnt;
  logic [11:0] avg_expected[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    logic [11:0] want;
    int unsigned acc;
    if (rst) begin
      leak_sum = '0;
      warm_cnt = '0;
      avg_expected.delete();
    end else begin
      // check the result first; a result never belongs to an item taken at the same edge
      if (out_valid && !out_stall) begin
        if (avg_expected.size() == 0) begin
          errors++;
          $display("%0t: average with nothing expected, got %0d", $time, average);
        end else begin
          want = avg_expected.pop_front();
          if (average !== want) begin
            errors++;
            $display("%0t: average expected %0d got %0d", $time, want, average);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (command == wla_pkg::CMD_CLEAR) begin
          leak_sum = '0;
          warm_cnt = '0;
        end else if (warm_cnt < WIN) begin
          acc      = leak_sum + sample;
          warm_cnt = warm_cnt + 1'b1;
          leak_sum = acc[15:0];
          acc      = acc / warm_cnt;
          avg_expected.push_back(acc[11:0]);
        end else begin
          // leak one window share, then add the new sample
          acc      = leak_sum - leak_sum / WIN + sample;
          leak_sum = acc[15:0];
          acc      = acc / WIN;
          avg_expected.push_back(acc[11:0]);
        end
      end
    end
    pending = avg_expected.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        command;
  logic [11:0] sample;
  logic        out_valid;
  logic        out_stall;
  logic [11:0] average;
  logic        quiet;
  int          errors;
  int          pending;

  warmup_leaky_average_filter_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .average   (average)
  );

  wla_avg_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .average   (average),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    command   = wla_pkg::CMD_SAMPLE;
    sample    = '0;
    out_stall = 1'b0;
    quiet     = 1'b0;
  end

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 32);
  end

  // one transfer on the input channel; returns right after the accepting edge
  task automatic send_item(input logic cmd, input logic [11:0] smp);
    @(negedge clk);
    while (!quiet && ($urandom_range(99) < 32)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    sample   <= smp;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [11:0] pick_sample();
    case ($urandom_range(9))
      0:       return 12'd0;
      1:       return 12'hFFF;
      2:       return 12'($urandom_range(15));
      3:       return 12'hFFF - 12'($urandom_range(15));
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: clear on empty state, extremes, full warm-up at max, leak down
    send_item(wla_pkg::CMD_CLEAR, 12'hFFF);
    send_item(wla_pkg::CMD_SAMPLE, 12'd0);
    send_item(wla_pkg::CMD_SAMPLE, 12'hFFF);
    send_item(wla_pkg::CMD_CLEAR, 12'd0);
    repeat (17) send_item(wla_pkg::CMD_SAMPLE, 12'hFFF);
    send_item(wla_pkg::CMD_SAMPLE, 12'd0);
    send_item(wla_pkg::CMD_SAMPLE, 12'd1);
    send_item(wla_pkg::CMD_CLEAR, 12'h5A5);
    send_item(wla_pkg::CMD_CLEAR, 12'hA5A);

    for (int i = 0; i < 450; i++) begin
      quiet = (i < 150);
      if (i == 300) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
      end
      if ($urandom_range(99) < 4)
        send_item(wla_pkg::CMD_CLEAR, 12'($urandom_range(4095)));
      else
        send_item(wla_pkg::CMD_SAMPLE, pick_sample());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wla_pkg.sv
rtl/wla_div.sv
rtl/wla_datapath.sv
rtl/wla_ctrl.sv
rtl/warmup_leaky_average_filter_core.sv
bench/wla_avg_checker.sv
bench/tb.sv
